FILE: rtl/core/skvt_pkg.sv
// Package for the small key-value table.
// Holds the field widths of the channels and the operation codes.
// No dependencies.
package skvt_pkg;

  // Channel field widths
  localparam int OP_W    = 2;
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 5;

  typedef logic [OP_W-1:0] op_t;

  // Operation codes
  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_DELETE = 2'd2;
  localparam op_t OP_CLEAR  = 2'd3;

endpackage

FILE: rtl/core/skvt_if.sv
// Valid/ready channel interfaces of the small key-value table.
// skvt_req_if carries requests, skvt_rsp_if carries results.
// Depends on skvt_pkg.
interface skvt_req_if;
  import skvt_pkg::*;

  logic               valid;
  logic               ready;
  op_t                operation;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface skvt_rsp_if;
  import skvt_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [VALUE_W-1:0] read_value;
  logic               refused;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, found, read_value, refused, entry_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, found, read_value, refused, entry_count, is_empty, is_full,
                  output ready);
endinterface

FILE: rtl/core/small_key_value_table.sv
// Top level of the small key-value table: a packed, unsorted list of keys and values.
// A small sequencer drives one memory read port and one key comparator over the entries.
// Depends on skvt_pkg and the channel interfaces in skvt_if.sv.
//
// Usage:
//   in_ch carries one request word (operation, key, value); out_ch returns one result word
//   per request (found, read_value, refused, entry_count, is_empty, is_full).
//   cfg_we/cfg_wdata write the miss value returned by a lookup that misses.
//   A request is taken only while the sequencer is idle. It then scans the stored keys
//   through the registered memory read port, one entry a cycle, until a match or the end
//   of the list. A delete that hits then moves every later entry down one slot through the
//   same port, one per cycle. The result register is then loaded, once the output slot is
//   free, and the sequencer returns to idle for the next request.
//   Reset empties the table and sets the miss value to zero; the entries themselves are
//   not cleared and need no clearing pass.
//   If the receiver stalls, the result waits in the output register; the next request
//   is still accepted and scanned, and it waits only to hand over its own result.
module small_key_value_table #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  skvt_req_if.sink                    in_ch,
  skvt_rsp_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [skvt_pkg::VALUE_W-1:0] cfg_wdata
);
  import skvt_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int KIN  = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int VIN  = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_PUT   = 2'd3;

  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  // Entry storage
  logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];

  // Control state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_addr_r, scan_addr_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [VALUE_W-1:0] miss_r;

  // Request and result payload
  op_t                    op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [KEY_WIDTH-1:0]   key_rd_r;
  logic [VALUE_WIDTH-1:0] val_rd_r;
  logic                   res_found_r, res_found_nxt;
  logic [VALUE_W-1:0]     res_rdval_r, res_rdval_nxt;
  logic                   res_refused_r, res_refused_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [VALUE_W-1:0]     out_rdval_r, out_rdval_nxt;
  logic                   out_refused_r, out_refused_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic                   out_empty_r, out_empty_nxt;
  logic                   out_full_r, out_full_nxt;

  // Memory write port
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [KEY_WIDTH-1:0]   mem_wk;
  logic [VALUE_WIDTH-1:0] mem_wv;

  logic                   accept;
  logic                   hit_now;
  logic                   scan_more;
  logic [CW-1:0]          addr_m1;
  logic [CW-1:0]          slot_p1;
  logic [VALUE_W-1:0]     hit_val;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // The comparator: a key read back last cycle against the requested key.
  assign hit_now   = pend_r && (key_rd_r == key_r);
  assign scan_more = (scan_addr_r < count_r);
  assign addr_m1   = scan_addr_r - 1'b1;
  assign slot_p1   = CW'(pend_idx_r) + 1'b1;
  assign hit_val   = VALUE_W'(val_rd_r[VIN-1:0]);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    scan_addr_nxt   = scan_addr_r;
    pend_nxt        = pend_r;
    pend_idx_nxt    = pend_idx_r;
    res_found_nxt   = res_found_r;
    res_rdval_nxt   = res_rdval_r;
    res_refused_nxt = res_refused_r;
    mem_we          = 1'b0;
    mem_wa          = pend_idx_r;
    mem_wk          = key_r;
    mem_wv          = val_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          scan_addr_nxt = '0;
          pend_nxt      = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now || !scan_more) begin
          // Scan resolved: act on the operation.
          res_found_nxt   = hit_now;
          res_rdval_nxt   = '0;
          res_refused_nxt = 1'b0;
          pend_nxt        = 1'b0;
          state_nxt       = ST_PUT;
          case (op_r)
            OP_LOOKUP: begin
              res_rdval_nxt = hit_now ? hit_val : miss_r;
            end
            OP_INSERT: begin
              if (!hit_now) begin
                if (count_r == FULL_COUNT) begin
                  res_refused_nxt = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  mem_wa    = count_r[AW-1:0];
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            OP_DELETE: begin
              if (hit_now) begin
                scan_addr_nxt = slot_p1;
                state_nxt     = ST_SHIFT;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              state_nxt = ST_PUT;
            end
          endcase
        end else begin
          // Read the next entry; it is compared in the following cycle.
          pend_nxt      = 1'b1;
          pend_idx_nxt  = scan_addr_r[AW-1:0];
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end
      ST_SHIFT: begin
        // Write back the entry read last cycle one slot lower.
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pend_idx_r;
          mem_wk = key_rd_r;
          mem_wv = val_rd_r;
        end
        if (scan_more) begin
          pend_nxt      = 1'b1;
          pend_idx_nxt  = addr_m1[AW-1:0];
          scan_addr_nxt = scan_addr_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = count_r - 1'b1;
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_vld_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded from the resolved result once the slot is free.
  always_comb begin
    out_vld_nxt     = out_vld_r && !out_ch.ready;
    out_found_nxt   = out_found_r;
    out_rdval_nxt   = out_rdval_r;
    out_refused_nxt = out_refused_r;
    out_count_nxt   = out_count_r;
    out_empty_nxt   = out_empty_r;
    out_full_nxt    = out_full_r;
    if (state_r == ST_PUT && (!out_vld_r || out_ch.ready)) begin
      out_vld_nxt     = 1'b1;
      out_found_nxt   = res_found_r;
      out_rdval_nxt   = res_rdval_r;
      out_refused_nxt = res_refused_r;
      out_count_nxt   = COUNT_W'(count_r);
      out_empty_nxt   = (count_r == '0);
      out_full_nxt    = (count_r == FULL_COUNT);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_addr_r <= '0;
      pend_r      <= 1'b0;
      pend_idx_r  <= '0;
      out_vld_r   <= 1'b0;
      miss_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_addr_r <= scan_addr_nxt;
      pend_r      <= pend_nxt;
      pend_idx_r  <= pend_idx_nxt;
      out_vld_r   <= out_vld_nxt;
      if (cfg_we) begin
        miss_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.operation;
      key_r <= KEY_WIDTH'(in_ch.key[KIN-1:0]);
      val_r <= VALUE_WIDTH'(in_ch.value[VIN-1:0]);
    end
    res_found_r   <= res_found_nxt;
    res_rdval_r   <= res_rdval_nxt;
    res_refused_r <= res_refused_nxt;
    out_found_r   <= out_found_nxt;
    out_rdval_r   <= out_rdval_nxt;
    out_refused_r <= out_refused_nxt;
    out_count_r   <= out_count_nxt;
    out_empty_r   <= out_empty_nxt;
    out_full_r    <= out_full_nxt;
  end

  // Entry memory: one write port, one registered read port at the scan address.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wk;
      val_mem[mem_wa] <= mem_wv;
    end
    key_rd_r <= key_mem[scan_addr_r[AW-1:0]];
    val_rd_r <= val_mem[scan_addr_r[AW-1:0]];
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.read_value  = out_rdval_r;
  assign out_ch.refused     = out_refused_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.is_full     = out_full_r;

  // The table never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count above capacity");

  // An accepted request always starts a scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SCAN)
    else $error("accepted request did not start a scan");

  // A finished shift removes exactly one entry.
  a_shift_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && state_nxt == ST_PUT) |=> count_r == CW'($past(count_r) - 1'b1))
    else $error("delete did not drop the count by one");

  // Writes land only inside the packed list or at its end.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_wa) <= count_r) && (count_r != FULL_COUNT || state_r == ST_SHIFT))
    else $error("entry write outside the packed list");

  // A refused insert never reports a present key and always reports a full table.
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_refused_r) |-> (!out_found_r && out_full_r))
    else $error("refused result with inconsistent flags");

endmodule

FILE: test/tb_top.sv
// Testbench for small_key_value_table: drives request words, predicts each result word
// from its own copy of the table and compares them field by field.
// Depends on skvt_pkg, the channel interfaces in skvt_if.sv and the table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import skvt_pkg::*;

  localparam int TABLE_DEPTH    = 16;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] read_value;
    logic               refused;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;
  } table_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [VALUE_W-1:0] cfg_wdata;

  skvt_req_if req_ch ();
  skvt_rsp_if rsp_ch ();

  small_key_value_table #(
    .CAPACITY   (TABLE_DEPTH),
    .KEY_WIDTH  (KEY_W),
    .VALUE_WIDTH(VALUE_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the table contents and the miss value register.
  logic [KEY_W-1:0]   model_keys   [TABLE_DEPTH];
  logic [VALUE_W-1:0] model_values [TABLE_DEPTH];
  int                 model_count = 0;
  logic [VALUE_W-1:0] model_miss_value = '0;

  table_result_t pending_results[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  in_gap_on    = 1'b1;
  bit  out_stall_on = 1'b1;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Apply one operation to the shadow table and return the result word it must produce.
  function automatic table_result_t predict_table_op(op_t op, logic [KEY_W-1:0] key,
                                                     logic [VALUE_W-1:0] value);
    table_result_t r;
    int slot;
    slot = -1;
    r = '0;
    for (int i = 0; i < model_count; i++) begin
      if (slot < 0 && model_keys[i] == key) slot = i;
    end
    r.found = (slot >= 0);
    case (op)
      OP_LOOKUP: begin
        r.read_value = (slot >= 0) ? model_values[slot] : model_miss_value;
      end
      OP_INSERT: begin
        if (slot < 0) begin
          if (model_count >= TABLE_DEPTH) begin
            r.refused = 1'b1;
          end else begin
            model_keys[model_count]   = key;
            model_values[model_count] = value;
            model_count++;
          end
        end
      end
      OP_DELETE: begin
        // Close the gap so the list stays packed.
        if (slot >= 0) begin
          for (int i = slot; i < model_count - 1; i++) begin
            model_keys[i]   = model_keys[i + 1];
            model_values[i] = model_values[i + 1];
          end
          model_count--;
        end
      end
      OP_CLEAR: begin
        model_count = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = COUNT_W'(model_count);
    r.is_empty    = (model_count == 0);
    r.is_full     = (model_count == TABLE_DEPTH);
    return r;
  endfunction

  // Send one request word and wait until it is accepted; maybe leave a gap afterwards.
  task automatic send_word(op_t op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    pending_results.push_back(predict_table_op(op, key, value));
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.key       <= key;
    req_ch.value     <= value;
    do @(posedge clk); while (!req_ch.ready);
    if (in_gap_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result word has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the miss value while the table is idle.
  task automatic set_miss_value(logic [VALUE_W-1:0] miss);
    wait_drained();
    cfg_wdata <= miss;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_miss_value = miss;
  endtask

  function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                      logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", VALUE_W'(want.found), VALUE_W'(rsp_ch.found));
        check_field("read_value", want.read_value, rsp_ch.read_value);
        check_field("refused", VALUE_W'(want.refused), VALUE_W'(rsp_ch.refused));
        check_field("entry_count", VALUE_W'(want.entry_count),
                    VALUE_W'(rsp_ch.entry_count));
        check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(rsp_ch.is_empty));
        check_field("is_full", VALUE_W'(want.is_full), VALUE_W'(rsp_ch.is_full));
      end
    end
  end

  // Receiver side: ready drops in random bursts.
  initial begin : result_ready_driver
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (out_stall_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // A lookup on the empty table must answer the miss value left by reset.
  task automatic test_empty_lookup();
    send_word(OP_LOOKUP, 16'h5A5A, 16'hFFFF);
    set_miss_value(16'hFFFF);
  endtask

  // Fill every slot, then try a new key and a present key against the full table.
  task automatic test_fill_and_refuse();
    send_word(OP_INSERT, 16'h0000, 16'hFFFF);
    send_word(OP_INSERT, 16'hFFFF, 16'h0000);
    for (int i = 0; i < TABLE_DEPTH - 2; i++) begin
      send_word(OP_INSERT, 16'h0001 << i, VALUE_W'($urandom_range(0, 65535)));
    end
    send_word(OP_INSERT, 16'h8001, 16'h1234);
    send_word(OP_INSERT, 16'h0004, 16'h4321);
    send_word(OP_LOOKUP, 16'hFFFF, 16'h0000);
  endtask

  // Delete from the middle and the end, miss cases, and a clear of a nearly full list.
  task automatic test_delete_and_clear();
    send_word(OP_DELETE, 16'h0004, 16'h0000);
    send_word(OP_LOOKUP, 16'h0008, 16'h0000);
    send_word(OP_DELETE, 16'h7777, 16'h0000);
    send_word(OP_LOOKUP, 16'h7777, 16'h0000);
    send_word(OP_DELETE, 16'h2000, 16'h0000);
    send_word(OP_CLEAR, 16'h0000, 16'h0000);
    send_word(OP_LOOKUP, 16'h0000, 16'h0000);
  endtask

  // Random traffic over a small key set so that hits, full tables and shifts are common.
  task automatic test_random_traffic(int n_words, int pool_n);
    logic [KEY_W-1:0] key_pool [24];
    logic [KEY_W-1:0] key;
    op_t op;
    int pick;
    for (int i = 0; i < pool_n; i++) key_pool[i] = KEY_W'($urandom_range(0, 65535));
    for (int n = 0; n < n_words; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) op = OP_INSERT;
      else if (pick < 68) op = OP_LOOKUP;
      else if (pick < 96) op = OP_DELETE;
      else op = OP_CLEAR;
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom_range(0, 65535));
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      // Let the table go fully idle once in the middle of the phase.
      if (n == n_words / 2) wait_drained();
      send_word(op, key, VALUE_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_LOOKUP;
    req_ch.key       <= '0;
    req_ch.value     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_lookup();
    test_fill_and_refuse();
    test_delete_and_clear();

    set_miss_value(16'h0000);
    test_random_traffic(350, 20);
    set_miss_value(VALUE_W'($urandom_range(0, 65535)));
    test_random_traffic(250, 6);
    set_miss_value(16'hFFFF);
    test_random_traffic(350, 24);
    set_miss_value(VALUE_W'($urandom_range(0, 65535)));
    test_random_traffic(300, 17);

    // Final stretch runs at full rate on both sides.
    in_gap_on    = 1'b0;
    out_stall_on = 1'b0;
    set_miss_value(VALUE_W'($urandom_range(0, 65535)));
    test_random_traffic(300, 18);

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/skvt_pkg.sv
rtl/core/skvt_if.sv
rtl/core/small_key_value_table.sv
test/tb_top.sv
